@@ rtl/core/rssyn_pkg.sv @@
package rssyn_pkg;

    localparam int GF_W          = 5;
    localparam int NUM_SYNDROMES = 20;
    localparam int BLOCK_LEN     = 31;
    localparam int CNT_W         = 5;
    localparam int IDX_W         = 5;

    localparam logic [GF_W-1:0]  GF_POLY_LOW   = 5'h05;
    localparam logic [CNT_W-1:0] LAST_COUNT    = CNT_W'(BLOCK_LEN - 1);
    localparam logic [IDX_W-1:0] FIRST_INDEX   = IDX_W'(1);
    localparam logic [IDX_W-1:0] LAST_INDEX    = IDX_W'(NUM_SYNDROMES);

    typedef logic [GF_W-1:0] t_gf;

    typedef struct packed {
        logic step;
        logic load;
        logic shift;
    } t_cell_ctrl;

    function automatic t_gf gf_times_x(input t_gf a);
        t_gf r;
        r = {a[GF_W-2:0], 1'b0};
        if (a[GF_W-1]) begin
            r = r ^ GF_POLY_LOW;
        end
        return r;
    endfunction

    function automatic t_gf gf_mul(input t_gf a, input t_gf b);
        t_gf acc;
        t_gf sh;
        acc = '0;
        sh  = a;
        for (int k = 0; k < GF_W; k++) begin
            if (b[k]) begin
                acc = acc ^ sh;
            end
            sh = gf_times_x(sh);
        end
        return acc;
    endfunction

    function automatic t_gf gf_alpha_pow(input int e);
        t_gf v;
        v = t_gf'(1);
        for (int k = 0; k < e; k++) begin
            v = gf_times_x(v);
        end
        return v;
    endfunction

endpackage

@@ rtl/core/rssyn_cell.sv @@
module rssyn_cell
    import rssyn_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_gf        i_alpha,
    input  t_gf        i_symbol,
    input  t_cell_ctrl i_ctrl,
    input  t_gf        i_hold_next,
    output t_gf        o_hold
);

    t_gf r_acc;
    t_gf n_acc;
    t_gf r_hold;
    t_gf n_hold;
    t_gf w_update;

    assign w_update = gf_mul(r_acc, i_alpha) ^ i_symbol;

    always_comb begin
        n_acc  = r_acc;
        n_hold = r_hold;
        if (i_ctrl.step) begin
            n_acc = i_ctrl.load ? '0 : w_update;
        end
        if (i_ctrl.load) begin
            n_hold = w_update;
        end else if (i_ctrl.shift) begin
            n_hold = i_hold_next;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc <= '0;
        end else begin
            r_acc <= n_acc;
        end
    end

    always_ff @(posedge i_clk) begin
        r_hold <= n_hold;
    end

    assign o_hold = r_hold;

endmodule

@@ rtl/core/rs_syndrome_gf32_top.sv @@
// Reed-Solomon syndrome calculator over GF(32), primitive polynomial x^5+x^2+1.
// Symbols enter one per cycle, highest degree first, in polynomial basis; every
// syndrome cell updates its accumulator S_i = S_i*alpha^i + r in the cycle of the
// transfer. On the last symbol the cells copy S_1..S_20 into an output shift
// chain and clear, and the next codeword can start at once; the chain then
// emits one syndrome per output transfer, index 1 first, with o_last_syndrome
// on S_20. A codeword gives 20 syndromes against 31 symbols, so with a free
// output the input never stalls. Only a codeword's last symbol waits, while
// the previous codeword's syndromes have not all been transferred.
module rs_syndrome_gf32_top
    import rssyn_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  logic [GF_W-1:0]  i_symbol,
    output logic             o_valid,
    input  logic             i_ready,
    output logic [IDX_W-1:0] o_syndrome_index,
    output logic [GF_W-1:0]  o_syndrome_value,
    output logic             o_last_syndrome
);

    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;
    logic             r_busy;
    logic             n_busy;
    logic [IDX_W-1:0] r_out_idx;
    logic [IDX_W-1:0] n_out_idx;

    logic       w_final;
    logic       w_in_xfer;
    logic       w_out_xfer;
    t_cell_ctrl w_ctrl;
    t_gf        w_hold [NUM_SYNDROMES+1];

    assign w_final    = (r_count == LAST_COUNT);
    assign o_ready    = !(w_final && r_busy);
    assign w_in_xfer  = i_valid && o_ready;
    assign o_valid    = r_busy;
    assign w_out_xfer = r_busy && i_ready;

    assign w_ctrl.step  = w_in_xfer;
    assign w_ctrl.load  = w_in_xfer && w_final;
    assign w_ctrl.shift = w_out_xfer;

    assign w_hold[NUM_SYNDROMES] = '0;

    for (genvar g = 0; g < NUM_SYNDROMES; g++) begin : g_cell
        rssyn_cell u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_alpha     (gf_alpha_pow(g + 1)),
            .i_symbol    (i_symbol),
            .i_ctrl      (w_ctrl),
            .i_hold_next (w_hold[g+1]),
            .o_hold      (w_hold[g])
        );
    end

    always_comb begin
        n_count   = r_count;
        n_busy    = r_busy;
        n_out_idx = r_out_idx;
        if (w_in_xfer) begin
            n_count = w_final ? '0 : r_count + CNT_W'(1);
        end
        if (w_ctrl.load) begin
            n_busy    = 1'b1;
            n_out_idx = FIRST_INDEX;
        end else if (w_out_xfer) begin
            n_out_idx = r_out_idx + IDX_W'(1);
            if (r_out_idx == LAST_INDEX) begin
                n_busy = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count   <= '0;
            r_busy    <= 1'b0;
            r_out_idx <= FIRST_INDEX;
        end else begin
            r_count   <= n_count;
            r_busy    <= n_busy;
            r_out_idx <= n_out_idx;
        end
    end

    assign o_syndrome_index = r_out_idx;
    assign o_syndrome_value = w_hold[0];
    assign o_last_syndrome  = (r_out_idx == LAST_INDEX);

endmodule

@@ dv/rs_syndrome_gf32_top_tb.sv @@
`timescale 1ns / 100ps

module rs_syndrome_gf32_top_tb;
    import rssyn_pkg::*;

    localparam int QUIET_LIMIT  = 4000;
    localparam int END_LATENCY  = 40;
    localparam int REPORT_LIMIT = 10;
    localparam int GEN_DEG      = NUM_SYNDROMES;
    localparam int MSG_LEN      = BLOCK_LEN - NUM_SYNDROMES;

    typedef enum {CW_ZERO, CW_FULL, CW_NOISE, CW_VALID, CW_CORRUPT} t_cw_kind;

    typedef struct packed {
        logic [IDX_W-1:0] index;
        t_gf              value;
        logic             last;
    } t_syndrome;

    logic             i_clk = 1'b0;
    logic             i_rst_n = 1'b0;
    logic             i_valid = 1'b0;
    logic             o_ready;
    logic [GF_W-1:0]  i_symbol = '0;
    logic             o_valid;
    logic             i_ready = 1'b0;
    logic [IDX_W-1:0] o_syndrome_index;
    logic [GF_W-1:0]  o_syndrome_value;
    logic             o_last_syndrome;

    t_gf       symbols_pending[$];
    t_syndrome syndromes_due[$];
    t_gf       horner_acc[NUM_SYNDROMES];
    int        symbols_seen = 0;

    int idle_pct = 0;
    int stall_pct = 0;
    int quiet_cycles = 0;
    int error_count = 0;
    int symbols_sent = 0;
    int codewords_done = 0;
    int syndromes_checked = 0;

    t_syndrome due;

    t_gf directed_syms[25] = '{
        5'd0, 5'd31, 5'd1, 5'd2, 5'd4, 5'd8, 5'd16, 5'd30, 5'd29, 5'd27,
        5'd23, 5'd15, 5'd0, 5'd0, 5'd31, 5'd31, 5'd5, 5'd10, 5'd20, 5'd21,
        5'd11, 5'd22, 5'd3, 5'd6, 5'd12
    };

    rs_syndrome_gf32_top DUT (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_ready          (o_ready),
        .i_symbol         (i_symbol),
        .o_valid          (o_valid),
        .i_ready          (i_ready),
        .o_syndrome_index (o_syndrome_index),
        .o_syndrome_value (o_syndrome_value),
        .o_last_syndrome  (o_last_syndrome)
    );

    always begin
        i_clk = 1'b0;
        #10;
        i_clk = 1'b1;
        #10;
    end

    function automatic t_gf gf_shift_up(input t_gf a);
        return {a[GF_W-2:0], 1'b0} ^ (a[GF_W-1] ? GF_POLY_LOW : t_gf'(0));
    endfunction

    function automatic t_gf gf_product(input t_gf a, input t_gf b);
        t_gf acc;
        t_gf sh;
        acc = '0;
        sh  = a;
        for (int k = 0; k < GF_W; k++) begin
            if (b[k]) begin
                acc = acc ^ sh;
            end
            sh = gf_shift_up(sh);
        end
        return acc;
    endfunction

    task automatic flag_error(input string msg);
        error_count++;
        if (error_count <= REPORT_LIMIT) begin
            $display("%0t: %s", $realtime, msg);
        end
    endtask

    // Every syndrome absorbs the symbol by Horner's rule; the last symbol of a
    // codeword releases all of them and clears the accumulators.
    task automatic absorb_symbol(input t_gf sym);
        t_gf apow;
        apow = t_gf'(1);
        for (int i = 0; i < NUM_SYNDROMES; i++) begin
            apow = gf_shift_up(apow);
            horner_acc[i] = gf_product(horner_acc[i], apow) ^ sym;
        end
        symbols_sent++;
        symbols_seen++;
        if (symbols_seen == BLOCK_LEN) begin
            for (int i = 0; i < NUM_SYNDROMES; i++) begin
                syndromes_due.push_back({IDX_W'(i + 1), horner_acc[i],
                                         i == NUM_SYNDROMES - 1});
                horner_acc[i] = '0;
            end
            symbols_seen = 0;
            codewords_done++;
        end
    endtask

    // Valid codewords are message times the generator with roots alpha^1..alpha^20.
    task automatic queue_codeword(input t_cw_kind kind);
        t_gf gen[GEN_DEG+1];
        t_gf msg[MSG_LEN];
        t_gf word[BLOCK_LEN];
        t_gf root;
        int  pos;
        foreach (gen[k]) begin
            gen[k] = '0;
        end
        gen[0] = t_gf'(1);
        root   = t_gf'(1);
        for (int i = 1; i <= GEN_DEG; i++) begin
            root = gf_shift_up(root);
            for (int j = i; j >= 0; j--) begin
                gen[j] = (j > 0 ? gen[j-1] : t_gf'(0)) ^ gf_product(gen[j], root);
            end
        end
        foreach (msg[k]) begin
            msg[k] = t_gf'($urandom_range(0, 31));
        end
        for (int k = 0; k < BLOCK_LEN; k++) begin
            word[k] = '0;
            for (int j = 0; j < MSG_LEN; j++) begin
                if (k - j >= 0 && k - j <= GEN_DEG) begin
                    word[k] = word[k] ^ gf_product(msg[j], gen[k-j]);
                end
            end
        end
        case (kind)
            CW_ZERO: begin
                foreach (word[k]) word[k] = '0;
            end
            CW_FULL: begin
                foreach (word[k]) word[k] = '1;
            end
            CW_NOISE: begin
                foreach (word[k]) word[k] = t_gf'($urandom_range(0, 31));
            end
            CW_CORRUPT: begin
                repeat ($urandom_range(1, 3)) begin
                    pos = $urandom_range(0, BLOCK_LEN - 1);
                    word[pos] = word[pos] ^ t_gf'($urandom_range(1, 31));
                end
            end
            default: begin
            end
        endcase
        for (int k = BLOCK_LEN - 1; k >= 0; k--) begin
            symbols_pending.push_back(word[k]);
        end
    endtask

    task automatic drain;
        while (symbols_pending.size() != 0 || i_valid || syndromes_due.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid  <= 1'b0;
            i_symbol <= '0;
        end else if (!i_valid || o_ready) begin
            if (i_valid) begin
                absorb_symbol(i_symbol);
            end
            if (symbols_pending.size() != 0 && $urandom_range(0, 99) >= idle_pct) begin
                i_valid  <= 1'b1;
                i_symbol <= symbols_pending.pop_front();
            end else begin
                i_valid  <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            if (syndromes_due.size() == 0) begin
                flag_error($sformatf("unexpected syndrome: index %0d value %0d last %0d",
                                     o_syndrome_index, o_syndrome_value, o_last_syndrome));
            end else begin
                due = syndromes_due.pop_front();
                syndromes_checked++;
                if (o_syndrome_index !== due.index || o_syndrome_value !== due.value ||
                    o_last_syndrome !== due.last) begin
                    flag_error($sformatf({"syndrome mismatch: expected index %0d value %0d ",
                                          "last %0d, got index %0d value %0d last %0d"},
                                         due.index, due.value, due.last, o_syndrome_index,
                                         o_syndrome_value, o_last_syndrome));
                end
            end
        end
        i_ready <= ($urandom_range(0, 99) >= stall_pct);
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && o_ready) || (o_valid && i_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("rs_syndrome_gf32_top: mismatch");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        foreach (horner_acc[i]) begin
            horner_acc[i] = '0;
        end
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        @(negedge i_clk);
        foreach (directed_syms[k]) begin
            symbols_pending.push_back(directed_syms[k]);
        end
        repeat (BLOCK_LEN - 25) symbols_pending.push_back(t_gf'($urandom_range(0, 31)));
        queue_codeword(CW_ZERO);
        queue_codeword(CW_FULL);
        queue_codeword(CW_VALID);
        drain();

        // The sender holds off at every phase change until all syndromes are out.
        for (int ph = 1; ph <= 3; ph++) begin
            @(posedge i_clk);
            idle_pct  <= (ph == 2) ? 0 : ((ph == 1) ? 83 : 31);
            stall_pct <= (ph == 1) ? 0 : ((ph == 2) ? 83 : 31);
            @(negedge i_clk);
            repeat (3) begin
                case ($urandom_range(0, 10))
                    0, 1, 2, 3: queue_codeword(CW_VALID);
                    4, 5, 6:    queue_codeword(CW_CORRUPT);
                    7, 8:       queue_codeword(CW_NOISE);
                    9:          queue_codeword(CW_ZERO);
                    default:    queue_codeword(CW_FULL);
                endcase
            end
            if (ph == 3) begin
                repeat (7) symbols_pending.push_back(t_gf'($urandom_range(0, 31)));
            end
            drain();
        end

        repeat (END_LATENCY) @(posedge i_clk);
        if (syndromes_due.size() != 0) begin
            flag_error($sformatf("%0d syndromes never arrived", syndromes_due.size()));
        end
        $display("Sent %0d symbols, %0d full codewords, %0d syndromes checked,",
                 symbols_sent, codewords_done, syndromes_checked);
        $display("across free flow, sender gaps, receiver stalls and both mixed.");
        if (error_count == 0) begin
            $display("rs_syndrome_gf32_top: match");
        end else begin
            $display("rs_syndrome_gf32_top: mismatch");
        end
        $finish;
    end

endmodule
